### hw/rtl/u8af_pkg.sv
// Package for the UTF-8 Latin to lowercase ASCII folding block.
// Holds the result word type, the Latin Extended-A range table and the fold function.
// No dependencies.
package u8af_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned LEAD_W = 5;
    localparam int unsigned EXT_N  = 21;
    localparam int unsigned IDX_W  = $clog2(EXT_N);

    localparam logic [CHAR_W-1:0] CH_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_C = 7'h63;
    localparam logic [CHAR_W-1:0] CH_E = 7'h65;
    localparam logic [CHAR_W-1:0] CH_I = 7'h69;
    localparam logic [CHAR_W-1:0] CH_J = 7'h6A;
    localparam logic [CHAR_W-1:0] CH_N = 7'h6E;
    localparam logic [CHAR_W-1:0] CH_O = 7'h6F;
    localparam logic [CHAR_W-1:0] CH_U = 7'h75;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 7'h20;

    // entries that expand to two letters
    localparam logic [BYTE_W-1:0] MARK_IJ = 8'h49;
    localparam logic [BYTE_W-1:0] MARK_OE = 8'h4F;

    localparam logic [BYTE_W-1:0] LEAD_LO = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_HI = 8'hDF;

    localparam logic [8:0] EXT_HI [EXT_N] = '{
        9'h105, 9'h10D, 9'h111, 9'h11B, 9'h123, 9'h127, 9'h131, 9'h133, 9'h135, 9'h138,
        9'h142, 9'h14B, 9'h151, 9'h153, 9'h159, 9'h161, 9'h167, 9'h173, 9'h175, 9'h178,
        9'h17E
    };
    localparam logic [BYTE_W-1:0] EXT_CH [EXT_N] = '{
        "a", "c", "d", "e", "g", "h", "i", "I", "j", "k",
        "l", "n", "o", "O", "r", "s", "t", "u", "w", "y",
        "z"
    };

    typedef struct packed {
        logic [1:0]        cnt;
        logic [CHAR_W-1:0] c0;
        logic [CHAR_W-1:0] c1;
    } t_fold;

    // fold the code point made of a held lead and its second byte
    function automatic t_fold fold_cp(input logic [LEAD_W-1:0] lead,
                                      input logic [BYTE_W-1:0] b);
        logic [12:0]       sum;
        logic [11:0]       cp;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] ch;
        t_fold             r;
        sum = {2'b00, lead, 6'b000000} + {5'b00000, b};
        cp  = sum[11:0] - 12'd128;
        idx = '0;
        ch  = '0;
        r   = '0;
        if (sum < 13'd128) begin
            r.cnt = 2'd1;
            r.c0  = CH_A;
        end else if (cp >= 12'h0C0 && cp <= 12'h0FF) begin
            case (cp[4:0]) inside
                [5'h00:5'h06]: begin r.cnt = 2'd1; r.c0 = CH_A; end
                5'h07:         begin r.cnt = 2'd1; r.c0 = CH_C; end
                [5'h08:5'h0B]: begin r.cnt = 2'd1; r.c0 = CH_E; end
                [5'h0C:5'h0F]: begin r.cnt = 2'd1; r.c0 = CH_I; end
                5'h11:         begin r.cnt = 2'd1; r.c0 = CH_N; end
                [5'h12:5'h16]: begin r.cnt = 2'd1; r.c0 = CH_O; end
                [5'h19:5'h1C]: begin r.cnt = 2'd1; r.c0 = CH_U; end
                default:       r.cnt = 2'd0;
            endcase
        end else if (cp >= 12'h100 && cp <= 12'h17E) begin
            for (int i = EXT_N - 1; i >= 0; i--) begin
                if (cp[8:0] <= EXT_HI[i]) begin
                    idx = IDX_W'(i);
                end
            end
            ch = EXT_CH[idx];
            if (ch == MARK_IJ) begin
                r.cnt = 2'd2;
                r.c0  = CH_I;
                r.c1  = CH_J;
            end else if (ch == MARK_OE) begin
                r.cnt = 2'd2;
                r.c0  = CH_O;
                r.c1  = CH_E;
            end else begin
                r.cnt = 2'd1;
                r.c0  = ch[CHAR_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/utf8_to_ascii_fold.sv
// Top level: folds a UTF-8 Latin byte stream to lowercase ASCII words.
// Path: a byte is registered in the input register, then folded into the result register on the master side.
// Throughput: 1 byte per cycle while the master side accepts every result; a byte that folds
// to two letters holds the fold stage while its second letter drains from the result register.
// Reset: synchronous, active low; clears the stage valids and the held lead byte.
// Depends on u8af_pkg.
module utf8_to_ascii_fold
    import u8af_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,    // [7:0] in_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,    // [6:0] out_char, [7] zero
    output logic              o_m_tlast     // run_last
);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_lead_pend;
    logic [LEAD_W-1:0] r_lead_bits;
    logic              r_out_vld;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_sec_vld;
    logic [CHAR_W-1:0] r_sec_char;

    logic  out_take;
    logic  consume;
    t_fold res;
    t_fold n_res;
    logic  n_lead_pend;
    logic  n_lead_set;

    assign out_take   = r_out_vld && i_m_tready;
    assign consume    = r_in_vld && (!r_out_vld || (out_take && !r_sec_vld));
    assign o_s_tready = !r_in_vld || consume;

    assign res = fold_cp(r_lead_bits, r_in_byte);

    always_comb begin
        n_res       = '0;
        n_lead_pend = 1'b0;
        n_lead_set  = 1'b0;
        if (r_in_byte == '0) begin
            n_res.cnt = 2'd1;
        end else if (r_lead_pend) begin
            n_res = res;
        end else if (!r_in_byte[BYTE_W-1]) begin
            n_res.cnt = 2'd1;
            n_res.c0  = r_in_byte[CHAR_W-1:0];
            if (r_in_byte[CHAR_W-1:0] >= CH_UPPER_A && r_in_byte[CHAR_W-1:0] <= CH_UPPER_Z) begin
                n_res.c0 = r_in_byte[CHAR_W-1:0] | CASE_BIT;
            end
        end else if (r_in_byte >= LEAD_LO && r_in_byte <= LEAD_HI) begin
            n_lead_pend = 1'b1;
            n_lead_set  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_lead_pend <= 1'b0;
            r_lead_bits <= '0;
            r_out_vld   <= 1'b0;
            r_sec_vld   <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (consume) begin
                r_lead_pend <= n_lead_pend;
                r_lead_bits <= n_lead_set ? r_in_byte[LEAD_W-1:0] : '0;
            end
            if (out_take && r_sec_vld) begin
                r_out_vld <= 1'b1;
                r_sec_vld <= 1'b0;
            end else if (consume) begin
                r_out_vld <= (n_res.cnt != 2'd0);
                r_sec_vld <= (n_res.cnt == 2'd2);
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (out_take && r_sec_vld) begin
            r_out_char <= r_sec_char;
            r_out_last <= 1'b1;
        end else if (consume) begin
            r_out_char <= n_res.c0;
            r_out_last <= (n_res.cnt != 2'd2);
            r_sec_char <= n_res.c1;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_char};
    assign o_m_tlast  = r_out_last;

endmodule

### hw/rtl/u8af_checker.sv
// Port checker for the UTF-8 to ASCII folding block, bound to its top level.
// Depends on u8af_pkg and utf8_to_ascii_fold.
module u8af_checker
    import u8af_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [7:0]        o_m_tdata,
    input logic              o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata == 8'h00 |-> o_m_tlast)
        else $error("terminator without tlast");

    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            o_m_tdata == {1'b0, CH_I} || o_m_tdata == {1'b0, CH_O})
        else $error("non-last word is not the first letter of a pair");

    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast && i_m_tready |=>
            o_m_tvalid && o_m_tlast &&
            (o_m_tdata == {1'b0, CH_J} || o_m_tdata == {1'b0, CH_E}))
        else $error("second letter of a pair missing");

endmodule

bind utf8_to_ascii_fold u8af_checker u_u8af_checker (.*);
